// ===== src/assert_macros.svh =====
// Assertion macros used by the guidance top level.
// WGS_ASSERT checks an implication in the same cycle.
// WGS_ASSERT_NEXT checks that the consequent holds in the cycle after the antecedent.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define WGS_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("guidance assertion failed");
`define WGS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("guidance sequencing assertion failed");
`else
`define WGS_ASSERT(label, clk, rst, prop)
`define WGS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== src/wgs_pkg.sv =====
package wgs_pkg;

  localparam logic [8:0] MAX_WAYPOINTS = 9'd256;

  localparam logic [1:0] ARM_NONE  = 2'd0;
  localparam logic [1:0] ARM_SET   = 2'd1;
  localparam logic [1:0] ARM_CLEAR = 2'd2;

  localparam logic [15:0] HEADING_RESET = 16'd0;
  localparam logic [7:0]  GAIN_RESET    = 8'd20;
  localparam logic [6:0]  LIMIT_RESET   = 7'd40;
  localparam logic [23:0] RADIUS_RESET  = 24'd1280;

  // Quarter-wave sine polynomial coefficients, Q14.
  localparam logic [14:0] SIN_C0  = 15'd25736;
  localparam logic [13:0] SIN_C1  = 14'd10583;
  localparam logic [14:0] SIN_C2  = 15'd1231;
  localparam logic [14:0] QUARTER = 15'd16384;
  localparam logic [7:0]  DRIVE_MAX = 8'd127;

  typedef enum logic [2:0] {
    REG_HEADING_YAW,
    REG_GAIN,
    REG_TOP_SPEED,
    REG_ARRIVE_RADIUS,
    REG_WAYPOINT_COUNT
  } wgs_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } wgs_state_t;

  typedef enum logic [2:0] {
    OP_SPEED,
    OP_Z2,
    OP_INNER,
    OP_POLY,
    OP_SINE,
    OP_DRIVE
  } wgs_op_t;

  typedef struct packed {
    logic [7:0]  gain;
    logic [23:0] distance;
    logic [6:0]  top_speed;
    logic [15:0] angle;
  } wgs_job_t;

  typedef struct packed {
    logic signed [7:0] aileron;
    logic signed [7:0] elevator;
  } wgs_drive_t;

endpackage

// ===== src/wgs_nav_if.sv =====
interface wgs_nav_if;
  logic        valid;
  logic        ready;
  logic [23:0] distance;
  logic [15:0] bearing;
  logic        auto_mode;
  logic [1:0]  arm_request;

  modport source(output valid, distance, bearing, auto_mode, arm_request, input ready);
  modport sink(input valid, distance, bearing, auto_mode, arm_request, output ready);
endinterface

// ===== src/wgs_cmd_if.sv =====
interface wgs_cmd_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] aileron;
  logic signed [7:0] elevator;
  logic [7:0]        waypoint_index;
  logic              arrived;
  logic              finished;
  logic              flying;

  modport source(output valid, aileron, elevator, waypoint_index, arrived, finished, flying,
                 input ready);
  modport sink(input valid, aileron, elevator, waypoint_index, arrived, finished, flying,
               output ready);
endinterface

// ===== src/wgs_cfg_if.sv =====
interface wgs_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [23:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== src/wgs_drive_unit.sv =====
module wgs_drive_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  wgs_pkg::wgs_job_t  job,
  output logic               done,
  output wgs_pkg::wgs_drive_t drv
);
  import wgs_pkg::*;

  // Control state.
  logic    busy, busy_next;
  wgs_op_t op, op_next;
  logic    cos_pass, cos_pass_next;

  // Operands and intermediate values.
  logic [7:0]  gain;
  logic [23:0] distance;
  logic [14:0] limit;
  logic [15:0] ang;
  logic [14:0] speed;
  logic [14:0] z2;
  logic [13:0] inner;
  logic [14:0] p;
  logic [14:0] sval;

  logic [14:0] z;
  logic        neg;
  logic [23:0] mul_a;
  logic [14:0] mul_b;
  logic [38:0] prod;
  logic [7:0]  mag;
  logic [7:0]  drive_val;

  // Fold the angle into the first quadrant; the lower half turn is negative.
  always_comb begin
    z   = ang[14] ? (QUARTER - {1'b0, ang[13:0]}) : {1'b0, ang[13:0]};
    neg = ang[15];
  end

  // The one shared multiplier.
  always_comb begin
    unique case (op)
      OP_SPEED: begin mul_a = distance;          mul_b = {7'd0, gain}; end
      OP_Z2:    begin mul_a = {9'd0, z};         mul_b = z;            end
      OP_INNER: begin mul_a = {9'd0, z2};        mul_b = SIN_C2;       end
      OP_POLY:  begin mul_a = {9'd0, z2};        mul_b = {1'b0, inner}; end
      OP_SINE:  begin mul_a = {9'd0, z};         mul_b = p;            end
      OP_DRIVE: begin mul_a = {9'd0, speed};     mul_b = sval;         end
      default:  begin mul_a = '0;                mul_b = '0;           end
    endcase
    prod = {15'd0, mul_a} * {24'd0, mul_b};
  end

  always_comb begin
    mag       = (prod[29:22] > DRIVE_MAX) ? DRIVE_MAX : prod[29:22];
    drive_val = neg ? (8'd0 - mag) : mag;
  end

  always_comb begin
    busy_next     = busy;
    op_next       = op;
    cos_pass_next = cos_pass;
    done          = 1'b0;
    if (start) begin
      busy_next     = 1'b1;
      op_next       = OP_SPEED;
      cos_pass_next = 1'b0;
    end else if (busy) begin
      unique case (op)
        OP_SPEED: op_next = OP_Z2;
        OP_Z2:    op_next = OP_INNER;
        OP_INNER: op_next = OP_POLY;
        OP_POLY:  op_next = OP_SINE;
        OP_SINE:  op_next = OP_DRIVE;
        OP_DRIVE: begin
          op_next = OP_Z2;
          if (cos_pass) begin
            busy_next = 1'b0;
            done      = 1'b1;
          end else begin
            cos_pass_next = 1'b1;
          end
        end
        default:  op_next = OP_SPEED;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      op       <= OP_SPEED;
      cos_pass <= 1'b0;
    end else begin
      busy     <= busy_next;
      op       <= op_next;
      cos_pass <= cos_pass_next;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      gain     <= job.gain;
      distance <= job.distance;
      limit    <= {job.top_speed, 8'd0};
      ang      <= job.angle;
    end else if (busy) begin
      unique case (op)
        OP_SPEED: speed <= (prod > {24'd0, limit}) ? limit : prod[14:0];
        OP_Z2:    z2    <= prod[28:14];
        OP_INNER: inner <= SIN_C1 - {3'd0, prod[24:14]};
        OP_POLY:  p     <= SIN_C0 - {1'b0, prod[27:14]};
        OP_SINE:  sval  <= prod[28:14];
        OP_DRIVE: begin
          if (cos_pass) begin
            drv.elevator <= drive_val;
          end else begin
            drv.aileron <= drive_val;
            ang         <= ang + 16'(QUARTER);
          end
        end
        default:  speed <= speed;
      endcase
    end
  end

endmodule

// ===== src/waypoint_guidance_step_top.sv =====
// Proportional waypoint guidance, one navigation tick per input beat.
// Channels: nav (sink) takes distance, bearing, auto_mode and arm_request;
// cmd (source) gives aileron, elevator, waypoint_index, arrived, finished and
// flying, exactly one beat per nav beat, in order. cfg (sink) writes the
// heading, gain, speed limit, arrival radius and waypoint count; it is always
// ready and is meant to be written only while no tick is in progress.
// The arm request, the flying decision, the arrival test and the waypoint
// index update all happen in the cycle the nav beat is taken.
// A steering tick then runs eleven passes through one shared 24x15
// multiplier (speed, then a five-pass sine polynomial and drive scaling for
// aileron and again for elevator) while nav is held not ready, so the block
// takes no new nav beat until the tick is through. Ticks that are not flying
// or that arrive at a waypoint skip the multiplier. The cmd beat is loaded
// into the output register as the tick leaves its finish state.
// The result sits in an output register, so a new nav beat is taken while a
// cmd beat waits; if cmd stays stalled, the finished tick waits in its last
// state and nav is held not ready. Synchronous reset disarms, clears the
// index and returns the state and configuration registers to their defaults.
module waypoint_guidance_step_top (
  input logic     clk,
  input logic     rst,
  wgs_nav_if.sink   nav,
  wgs_cmd_if.source cmd,
  wgs_cfg_if.sink   cfg
);
  import wgs_pkg::*;

  `include "assert_macros.svh"

  // Configuration registers.
  logic [15:0] heading_yaw;
  logic [7:0]  gain;
  logic [6:0]  top_speed;
  logic [23:0] arrive_radius;
  logic [8:0]  waypoint_count;

  // Guidance state.
  logic       armed, armed_next;
  logic [7:0] target_index, target_index_next;

  wgs_state_t state, state_next;

  // Facts about the tick in flight.
  logic res_flying, res_arrived, res_finished, res_zero;

  // Output register.
  logic out_valid;

  logic       accept;
  logic       out_load;
  logic       armed_req;
  logic       flying;
  logic       arrive;
  logic       last_wp;
  logic [8:0] idx_inc;
  logic [8:0] count_sat;

  wgs_job_t   job;
  wgs_drive_t drv;
  logic       unit_done;

  assign cfg.ready = 1'b1;
  assign nav.ready = (state == ST_IDLE);
  assign accept    = nav.valid && nav.ready;
  assign cmd.valid = out_valid;

  // The count register saturates at the table depth.
  assign count_sat = (cfg.data[8:0] > MAX_WAYPOINTS) ? MAX_WAYPOINTS : cfg.data[8:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      heading_yaw    <= HEADING_RESET;
      gain           <= GAIN_RESET;
      top_speed      <= LIMIT_RESET;
      arrive_radius  <= RADIUS_RESET;
      waypoint_count <= '0;
    end else if (cfg.valid) begin
      unique case (wgs_reg_t'(cfg.index))
        REG_HEADING_YAW:    heading_yaw    <= cfg.data[15:0];
        REG_GAIN:           gain           <= cfg.data[7:0];
        REG_TOP_SPEED:      top_speed      <= cfg.data[6:0];
        REG_ARRIVE_RADIUS:  arrive_radius  <= cfg.data;
        REG_WAYPOINT_COUNT: waypoint_count <= count_sat;
        default:            heading_yaw    <= heading_yaw;
      endcase
    end
  end

  // The arm request is applied first; flying is judged on the updated flag.
  always_comb begin
    unique case (nav.arm_request)
      ARM_SET:   armed_req = 1'b1;
      ARM_CLEAR: armed_req = 1'b0;
      default:   armed_req = armed;
    endcase
    flying  = nav.auto_mode && armed_req && (waypoint_count != 9'd0);
    arrive  = flying && (nav.distance < arrive_radius);
    idx_inc = {1'b0, target_index} + 9'd1;
    last_wp = (idx_inc >= waypoint_count);

    armed_next        = armed_req;
    target_index_next = target_index;
    if (arrive) begin
      if (last_wp) begin
        target_index_next = '0;
        armed_next        = 1'b0;
      end else begin
        target_index_next = idx_inc[7:0];
      end
    end

    job.gain        = gain;
    job.distance    = nav.distance;
    job.top_speed   = top_speed;
    job.angle       = nav.bearing - heading_yaw;
  end

  always_comb begin
    state_next = state;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (flying && !arrive) ? ST_RUN : ST_FINISH;
        end
      end
      ST_RUN: begin
        if (unit_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid || cmd.ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      armed        <= 1'b0;
      target_index <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        armed        <= armed_next;
        target_index <= target_index_next;
      end else if (cfg.valid && (wgs_reg_t'(cfg.index) == REG_WAYPOINT_COUNT)) begin
        target_index <= '0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (cmd.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_flying   <= flying;
      res_arrived  <= arrive;
      res_finished <= arrive && last_wp;
      res_zero     <= !(flying && !arrive);
    end
    if (out_load) begin
      cmd.aileron        <= res_zero ? 8'sd0 : drv.aileron;
      cmd.elevator       <= res_zero ? 8'sd0 : drv.elevator;
      cmd.waypoint_index <= target_index;
      cmd.arrived        <= res_arrived;
      cmd.finished       <= res_finished;
      cmd.flying         <= res_flying;
    end
  end

  wgs_drive_unit u_drive (
    .clk   (clk),
    .rst   (rst),
    .start (accept && flying && !arrive),
    .job   (job),
    .done  (unit_done),
    .drv   (drv)
  );

  // Steering output only ever comes from a flying tick that did not arrive.
  `WGS_ASSERT(a_drive_only_steering, clk, rst, out_valid && (cmd.aileron != 8'sd0 || cmd.elevator != 8'sd0) |-> cmd.flying && !cmd.arrived)
  // Finishing the route is an arrival that wraps the index to zero.
  `WGS_ASSERT(a_finish_wraps, clk, rst, out_valid && cmd.finished |-> cmd.arrived && cmd.waypoint_index == 8'd0)
  // Drive magnitude is clamped, so the most negative code never appears.
  `WGS_ASSERT(a_drive_range, clk, rst, out_valid |-> cmd.aileron != 8'sh80 && cmd.elevator != 8'sh80)
  // The multiplier only finishes while a steering tick is in progress.
  `WGS_ASSERT(a_done_in_run, clk, rst, unit_done |-> state == ST_RUN)
  // A taken tick always moves the block out of idle, dropping nav ready.
  `WGS_ASSERT_NEXT(a_busy_after_accept, clk, rst, nav.valid && nav.ready, !nav.ready)

endmodule
